@@ src/crwq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crwq_pkg;

   localparam int TGT_W    = 5;
   localparam int VAL_W    = 8;
   localparam int DEV_W    = 7;
   localparam int REG_W    = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [DEV_W-1:0] DEV_ADDR_0 = 7'h69;
   localparam logic [DEV_W-1:0] DEV_ADDR_1 = 7'h24;
   localparam logic [DEV_W-1:0] DEV_ADDR_2 = 7'h1e;

   // first target index of the second and third device
   localparam logic [TGT_W-1:0] DEV_1_BASE = 5'd4;
   localparam logic [TGT_W-1:0] DEV_2_BASE = 5'd11;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FORCE = 2'd1,
      OP_DRAIN = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_QUEUED    = 3'd0,
      ST_DISCARDED = 3'd1,
      ST_INVALID   = 3'd2,
      ST_DRAINED   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [DEV_W-1:0] dev_addr;
      logic [REG_W-1:0] dev_reg;
   } map_type;

   function automatic map_type map_target(input logic [TGT_W-1:0] tgt);
      map_type m;
      logic [TGT_W-1:0] offs;
      if (tgt < DEV_1_BASE) begin
         m.dev_addr = DEV_ADDR_0;
         offs       = tgt;
      end else if (tgt < DEV_2_BASE) begin
         m.dev_addr = DEV_ADDR_1;
         offs       = tgt - DEV_1_BASE;
      end else begin
         m.dev_addr = DEV_ADDR_2;
         offs       = tgt - DEV_2_BASE;
      end
      m.dev_reg = {{(REG_W-TGT_W){1'b0}}, offs};
      return m;
   endfunction

endpackage

`default_nettype wire

@@ src/coalescing_register_write_queue.sv @@
// Coalescing register write queue.
// req_ beats carry an operation in tuser (write if changed, forced write,
// drain) with a target index and a byte in tdata. Each accepted beat gives
// exactly one rsp_ beat: a status in tuser and, for a drain, the popped
// target, its device address, register number and current byte in tdata.
// A write (not forced) equal to the shadow byte is dropped, and a write to a
// target out of range is refused; otherwise the shadow byte is updated and
// the target joins the tail of the pending list unless it is already there,
// in which case it keeps its place and sends the new byte. A beat accepted
// into the input register moves on to the result register and so to rsp_.
// Throughput: one beat per cycle while rsp_ is not stalled; the shadow,
// flag and link updates all complete as a beat passes to the result register.
// A stalled rsp_ holds the result register; the input register then holds
// its beat and req_tready drops once it is full.
// Reset (synchronous, active high) empties the list, clears every shadow
// byte and leaves both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module coalescing_register_write_queue
   import crwq_pkg::*;
#(
   parameter int NUM_TARGETS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [4:0] target_index, [12:5] write_value, [15:13] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]            req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [4:0] out_target, [11:5] device_address, [19:12] device_register,
   // [27:20] out_value, [31:28] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output      logic [2:0]            rsp_tuser
);

   localparam int IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
   localparam logic [TGT_W:0] NUM_TGT = (TGT_W+1)'(NUM_TARGETS);

   // input register
   logic             in_valid_ff;
   logic [1:0]       op_ff;
   logic [TGT_W-1:0] tgt_ff;
   logic [VAL_W-1:0] val_ff;

   // result register
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [2:0]            out_status_ff;
   logic [RSP_DATA_W-1:0] out_data_in;
   logic [2:0]            out_status_in;

   // list state
   logic [VAL_W-1:0] shadow_ff [NUM_TARGETS];
   logic             queued_ff [NUM_TARGETS];
   logic [IDX_W-1:0] link_ff   [NUM_TARGETS];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             nonempty_ff, nonempty_in;

   logic             advance, fire;
   logic             is_drain, is_write, tgt_ok;
   logic [IDX_W-1:0] tgt_idx, rd_idx;
   logic [VAL_W-1:0] shadow_rd;
   logic             queued_rd;
   logic             shadow_we, append, pop;
   map_type          head_map;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign is_drain = (op_ff == OP_DRAIN);
   assign is_write = (op_ff == OP_WRITE) || (op_ff == OP_FORCE);
   assign tgt_ok   = ({1'b0, tgt_ff} < NUM_TGT);
   assign tgt_idx  = tgt_ff[IDX_W-1:0];

   // one shared read port: the head for a drain, the target for a write
   assign rd_idx    = is_drain ? head_ff : tgt_idx;
   assign shadow_rd = shadow_ff[rd_idx];
   assign queued_rd = queued_ff[rd_idx];
   assign head_map  = map_target(TGT_W'(head_ff));

   always_comb begin
      shadow_we     = 1'b0;
      append        = 1'b0;
      pop           = 1'b0;
      out_status_in = ST_INVALID;
      out_data_in   = '0;
      if (is_drain) begin
         if (nonempty_ff) begin
            pop           = 1'b1;
            out_status_in = ST_DRAINED;
            out_data_in   = {{(RSP_DATA_W-TGT_W-DEV_W-REG_W-VAL_W){1'b0}},
                             shadow_rd, head_map.dev_reg, head_map.dev_addr,
                             TGT_W'(head_ff)};
         end else begin
            out_status_in = ST_EMPTY;
         end
      end else if (is_write && tgt_ok) begin
         if (op_ff == OP_WRITE && shadow_rd == val_ff) begin
            out_status_in = ST_DISCARDED;
         end else begin
            shadow_we     = 1'b1;
            append        = !queued_rd;
            out_status_in = ST_QUEUED;
         end
      end
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      nonempty_in = nonempty_ff;
      if (append) begin
         tail_in     = tgt_idx;
         nonempty_in = 1'b1;
         if (!nonempty_ff) begin
            head_in = tgt_idx;
         end
      end else if (pop) begin
         if (head_ff == tail_ff) begin
            nonempty_in = 1'b0;
         end else begin
            head_in = link_ff[head_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff  <= req_tuser;
         tgt_ff <= req_tdata[TGT_W-1:0];
         val_ff <= req_tdata[TGT_W+VAL_W-1:TGT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff   <= out_data_in;
         out_status_ff <= out_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         nonempty_ff <= 1'b0;
      end else if (fire) begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         nonempty_ff <= nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TARGETS; i++) begin
            shadow_ff[i] <= '0;
            queued_ff[i] <= 1'b0;
         end
      end else if (fire) begin
         if (shadow_we) begin
            shadow_ff[tgt_idx] <= val_ff;
         end
         if (append) begin
            queued_ff[tgt_idx] <= 1'b1;
         end else if (pop) begin
            queued_ff[head_ff] <= 1'b0;
         end
      end
   end

   // links need no reset: one is read only while its target is queued
   always_ff @(posedge clock) begin
      if (fire && append && nonempty_ff) begin
         link_ff[tail_ff] <= tgt_idx;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire

@@ src/crwq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crwq_checker
   import crwq_pkg::*;
#(
   parameter int NUM_TARGETS = 24
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [2:0]            rsp_tuser
);

   localparam logic [TGT_W:0] NUM_TGT = (TGT_W+1)'(NUM_TARGETS);

   map_type rsp_map;
   assign rsp_map = map_target(rsp_tdata[TGT_W-1:0]);

   // nothing may come out of a freshly reset block
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // a beat taken while the result is stalled fills both registers
   a_fill_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && (req_tready == rsp_tready))
      else $error("input ready does not follow the stalled receiver");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DRAINED |-> rsp_tdata == '0)
      else $error("non-drain result carries data");

   a_drain_map: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DRAINED |->
         {1'b0, rsp_tdata[TGT_W-1:0]} < NUM_TGT
         && rsp_tdata[TGT_W+DEV_W-1:TGT_W] == rsp_map.dev_addr
         && rsp_tdata[TGT_W+DEV_W+REG_W-1:TGT_W+DEV_W] == rsp_map.dev_reg)
      else $error("drained target does not match its device map");

endmodule

bind coalescing_register_write_queue crwq_checker #(
   .NUM_TARGETS(NUM_TARGETS)
) u_crwq_checker (.*);

`default_nettype wire
